### hw/rtl/sbrl_pkg.sv
package sbrl_pkg;

    // Reads in flight at most.
    localparam int unsigned MAX_OUTSTANDING = 2;
    localparam int unsigned OUT_CNT_W = $clog2(MAX_OUTSTANDING + 1);

    // Register field widths.
    localparam int unsigned BASE_W   = 20;
    localparam int unsigned STRIDE_W = 16;
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned LEN_W    = 17;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    // Largest log2 code that is not saturated.
    localparam int unsigned LOG2_CODE_MAX = 16;

    // Command codes.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ISSUE = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_PAGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_CODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2  = 2'd3;

    // Result kinds.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_FORWARD = 1'b1;

    typedef struct packed {
        logic [1:0]        command;
        logic [DATA_W-1:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] read_address;
        logic [DATA_W-1:0] forward_data;
        logic              batch_done;
    } out_item_t;

    typedef struct packed {
        logic [BASE_W-1:0]   base_page;
        logic [STRIDE_W-1:0] stride_words;
        logic [CODE_W-1:0]   batch_size_code;
        logic                size_is_log2;
    } cfg_t;

    // Work handed from the control stage to the address stage.
    typedef struct packed {
        logic                kind;
        logic [INDEX_W-1:0]  index;
        logic [STRIDE_W-1:0] stride_words;
        logic [BASE_W-1:0]   base_page;
        logic [DATA_W-1:0]   data;
        logic                done;
    } stage_t;

    // Control status seen by the top level.
    typedef struct packed {
        logic                 armed;
        logic                 issuing;
        logic [OUT_CNT_W-1:0] outstanding;
    } status_t;

endpackage

### hw/rtl/sbrl_cfg.sv
module sbrl_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               we,
    input  logic [sbrl_pkg::CFG_IDX_W-1:0]     index,
    input  logic [sbrl_pkg::CFG_DATA_W-1:0]    data,
    output sbrl_pkg::cfg_t                     cfg
);

    sbrl_pkg::cfg_t cfg_reg;
    sbrl_pkg::cfg_t cfg_next;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (index)
                sbrl_pkg::REG_BASE_PAGE:
                    cfg_next.base_page = data[sbrl_pkg::BASE_W-1:0];
                sbrl_pkg::REG_STRIDE:
                    cfg_next.stride_words = data[sbrl_pkg::STRIDE_W-1:0];
                sbrl_pkg::REG_SIZE_CODE:
                    cfg_next.batch_size_code = data[sbrl_pkg::CODE_W-1:0];
                sbrl_pkg::REG_SIZE_LOG2:
                    cfg_next.size_is_log2 = data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_page       <= '0;
            cfg_reg.stride_words    <= sbrl_pkg::STRIDE_W'(1);
            cfg_reg.batch_size_code <= '0;
            cfg_reg.size_is_log2    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/sbrl_ctrl.sv
module sbrl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbrl_pkg::cfg_t        cfg,
    input  logic                  cfg_we,
    input  logic                  accept,
    input  sbrl_pkg::in_item_t    item,
    output logic                  load,
    output sbrl_pkg::stage_t      entry,
    output sbrl_pkg::status_t     status
);

    logic                                armed_reg, armed_next;
    logic                                issuing_reg, issuing_next;
    logic [sbrl_pkg::LEN_W-1:0]          count_reg, count_next;
    logic [sbrl_pkg::OUT_CNT_W-1:0]      outst_reg, outst_next;
    logic [sbrl_pkg::LEN_W-1:0]          read_total;
    logic [sbrl_pkg::LEN_W-1:0]          count_inc;
    logic                                issue_ok;

    // Batch length, read live from the registers.
    always_comb
    begin
        if (cfg.size_is_log2)
        begin
            if (cfg.batch_size_code > sbrl_pkg::CODE_W'(sbrl_pkg::LOG2_CODE_MAX))
                read_total = sbrl_pkg::LEN_W'(1) << sbrl_pkg::LOG2_CODE_MAX;
            else
                read_total = sbrl_pkg::LEN_W'(1) << cfg.batch_size_code[4:0];
        end
        else
        begin
            read_total = sbrl_pkg::LEN_W'(cfg.batch_size_code);
        end
    end

    assign count_inc = count_reg + sbrl_pkg::LEN_W'(1);
    assign issue_ok  = issuing_reg && (count_reg < read_total)
                    && (outst_reg < sbrl_pkg::OUT_CNT_W'(sbrl_pkg::MAX_OUTSTANDING));

    // Command handling and next state.
    always_comb
    begin
        armed_next   = armed_reg;
        issuing_next = issuing_reg;
        count_next   = count_reg;
        outst_next   = outst_reg;
        load         = 1'b0;
        entry.kind         = sbrl_pkg::KIND_REQUEST;
        entry.index        = count_reg[sbrl_pkg::INDEX_W-1:0];
        entry.stride_words = cfg.stride_words;
        entry.base_page    = cfg.base_page;
        entry.data         = item.read_data;
        entry.done         = 1'b0;

        if (accept)
        begin
            unique case (item.command)
                sbrl_pkg::CMD_START:
                begin
                    if (armed_reg)
                    begin
                        armed_next   = 1'b0;
                        count_next   = '0;
                        issuing_next = (read_total != '0);
                    end
                end
                sbrl_pkg::CMD_ISSUE:
                begin
                    if (issue_ok)
                    begin
                        load       = 1'b1;
                        count_next = count_inc;
                        outst_next = outst_reg + sbrl_pkg::OUT_CNT_W'(1);
                        if (count_inc >= read_total)
                            issuing_next = 1'b0;
                    end
                end
                sbrl_pkg::CMD_DATA:
                begin
                    load       = 1'b1;
                    entry.kind = sbrl_pkg::KIND_FORWARD;
                    if (outst_reg != '0)
                    begin
                        outst_next = outst_reg - sbrl_pkg::OUT_CNT_W'(1);
                        entry.done = !issuing_reg
                                  && (outst_reg == sbrl_pkg::OUT_CNT_W'(1));
                    end
                end
                sbrl_pkg::CMD_NONE:
                begin
                    load = 1'b0;
                end
                default:
                begin
                    load = 1'b0;
                end
            endcase
        end

        // A register write arms the next start; it lands after a beat of the same cycle.
        if (cfg_we)
        begin
            armed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            issuing_reg <= 1'b0;
            count_reg   <= '0;
            outst_reg   <= '0;
        end
        else
        begin
            armed_reg   <= armed_next;
            issuing_reg <= issuing_next;
            count_reg   <= count_next;
            outst_reg   <= outst_next;
        end
    end

    assign status.armed       = armed_reg;
    assign status.issuing     = issuing_reg;
    assign status.outstanding = outst_reg;

endmodule

### hw/rtl/sbrl_out.sv
module sbrl_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  sbrl_pkg::stage_t      entry,
    output logic                  can_take,
    output logic                  valid,
    input  logic                  ready,
    output sbrl_pkg::out_item_t   item
);

    logic                                      s1_valid_reg, s1_valid_next;
    sbrl_pkg::stage_t                          s1_reg;
    logic                                      out_valid_reg, out_valid_next;
    sbrl_pkg::out_item_t                       out_reg, result;
    logic                                      s1_move;
    logic [2*sbrl_pkg::INDEX_W-1:0]            offset_words;

    // The stage moves on whenever the output register is empty or drained.
    assign s1_move  = !out_valid_reg || ready;
    assign can_take = !s1_valid_reg || s1_move;

    // Address generation: one 16x16 multiply and one add.
    assign offset_words = s1_reg.index * s1_reg.stride_words;

    always_comb
    begin
        if (s1_reg.kind == sbrl_pkg::KIND_REQUEST)
        begin
            result.kind         = sbrl_pkg::KIND_REQUEST;
            result.read_address = {s1_reg.base_page, 12'h000}
                                + {offset_words[sbrl_pkg::ADDR_W-3:0], 2'b00};
            result.forward_data = '0;
            result.batch_done   = 1'b0;
        end
        else
        begin
            result.kind         = sbrl_pkg::KIND_FORWARD;
            result.read_address = '0;
            result.forward_data = s1_reg.data;
            result.batch_done   = s1_reg.done;
        end
    end

    // Valid flags for both stages.
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (load)
            s1_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
            s1_reg <= entry;
        if (s1_move && s1_valid_reg)
            out_reg <= result;
    end

    assign valid = out_valid_reg;
    assign item  = out_reg;

endmodule

### hw/rtl/strided_batch_read_loader_core.sv
// Channel    Signals                           Beat
// --------   -------------------------------   -------------------------------
// input      in_valid, in_ready, in_data       one command with its data word
// output     out_valid, out_ready, out_data    one read request or forwarded word
// config     cfg_we, cfg_index, cfg_data       one register write, no wait
//
// One beat is taken every cycle while in_ready is high; a result passes the address stage and then the output register.
// The control state updates at the input beat; the multiply sits in the next stage.
// Reset clears the control state and loads stride_words with one.
// in_ready drops only while both the address stage and the output register hold beats.
module strided_batch_read_loader_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  sbrl_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output sbrl_pkg::out_item_t                out_data,
    input  logic                               cfg_we,
    input  logic [sbrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbrl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    sbrl_pkg::cfg_t     cfg;
    sbrl_pkg::stage_t   entry;
    sbrl_pkg::status_t  status;
    logic               load;
    logic               accept;

    assign accept = in_valid && in_ready;

    // Configuration registers.
    sbrl_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    // Batch control and counters.
    sbrl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cfg_we (cfg_we),
        .accept (accept),
        .item   (in_data),
        .load   (load),
        .entry  (entry),
        .status (status)
    );

    // Address stage and output register.
    sbrl_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .entry    (entry),
        .can_take (in_ready),
        .valid    (out_valid),
        .ready    (out_ready),
        .item     (out_data)
    );

    // The outstanding count never passes the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.outstanding <= sbrl_pkg::OUT_CNT_W'(sbrl_pkg::MAX_OUTSTANDING))
        else $error("outstanding read count above limit");

    // Only forwarded words carry the done flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.batch_done |-> out_data.kind == sbrl_pkg::KIND_FORWARD)
        else $error("done flag on a read request");

    // Input stalls only while the output side is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // A done word leaves nothing outstanding and no batch issuing.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && load && entry.done |=> status.outstanding == '0 && !status.issuing)
        else $error("done flag with reads still pending");

endmodule
